[design/u2d_pkg.sv]
// Shared types and constants for the UTF-8 to UCS-2 decoder.
// No dependencies; imported by every module of the block.
package u2d_pkg;

    localparam int unsigned QueueDepthDefault = 2;

    localparam logic [15:0] MaxUnitsReset = 16'hFFFF;

    // byte-order mark
    localparam logic [7:0] BomByte0 = 8'hEF;
    localparam logic [7:0] BomByte1 = 8'hBB;
    localparam logic [7:0] BomByte2 = 8'hBF;

    // lead byte classification
    localparam logic [7:0] Lead2Mask  = 8'hE0;
    localparam logic [7:0] Lead2Code  = 8'hC0;
    localparam logic [7:0] Lead3Mask  = 8'hF0;
    localparam logic [7:0] Lead3Code  = 8'hE0;
    localparam logic [7:0] Lead4Mask  = 8'hF8;
    localparam logic [7:0] Lead4Code  = 8'hF0;
    localparam logic [7:0] Lead5Mask  = 8'hFC;
    localparam logic [7:0] Lead5Code  = 8'hF8;
    localparam logic [7:0] Lead6Mask  = 8'hFE;
    localparam logic [7:0] Lead6Code  = 8'hFC;

    localparam logic [1:0] PosBomLast = 2'd2;
    localparam logic [1:0] PosSat     = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_valid;
        logic        end_of_string;
        logic [15:0] units_written;
        logic        stopped_full;
    } t_out_item;

    // entry carried from front to back
    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_valid;
        logic        end_of_string;
        logic [15:0] units_written;
    } t_q_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[design/u2d_front.sv]
// Front end: accepts bytes, tracks sequence state and decodes code units.
// Depends on u2d_pkg; pushes results into u2d_queue.
module u2d_front
    import u2d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    input  logic [15:0] i_max_units,
    input  t_q_status   i_q_status,
    output logic        o_push,
    output t_q_item     o_push_item
);

    logic [2:0]  r_pending, n_pending;
    logic        r_skip, n_skip;
    logic [15:0] r_acc, n_acc;
    logic [1:0]  r_pos, n_pos;
    logic        r_bom, n_bom;
    logic [15:0] r_count, n_count;
    logic        r_term, n_term;

    logic        accept;
    logic [7:0]  b;
    logic [7:0]  want;
    logic        mark_done;
    logic        emit;
    logic        unit_ok;
    logic        end_s;
    logic [15:0] unit;

    assign o_in_ready = !i_q_status.full;
    assign accept     = i_in_valid && o_in_ready;
    assign b          = i_in_item.in_byte;

    always_comb begin
        n_pending = r_pending;
        n_skip    = r_skip;
        n_acc     = r_acc;
        n_pos     = r_pos;
        n_bom     = r_bom;
        n_count   = r_count;
        n_term    = r_term;
        mark_done = 1'b0;
        emit      = 1'b0;
        unit_ok   = 1'b0;
        end_s     = 1'b0;
        unit      = 16'd0;
        want      = (r_pos == 2'd0) ? BomByte0 : (r_pos == 2'd1) ? BomByte1 : BomByte2;
        if (accept && !r_term) begin
            if (b == 8'd0) begin
                end_s = 1'b1;
            end else if (r_count >= i_max_units) begin
                n_pending = 3'd0;
                n_skip    = 1'b0;
            end else begin
                if (r_bom) begin
                    if (r_pos == PosSat || b != want) begin
                        n_bom = 1'b0;
                    end else if (r_pos == PosBomLast) begin
                        mark_done = 1'b1;
                    end
                end
                if (r_pos != PosSat) begin
                    n_pos = r_pos + 2'd1;
                end

                if (r_pending != 3'd0) begin
                    n_pending = r_pending - 3'd1;
                    if (!r_skip) begin
                        n_acc = {r_acc[9:0], b[5:0]};
                        if (r_pending == 3'd1) begin
                            emit = 1'b1;
                        end
                    end else if (r_pending == 3'd1) begin
                        n_skip = 1'b0;
                    end
                end else if (!b[7]) begin
                    n_acc = {8'd0, b};
                    emit  = 1'b1;
                end else if ((b & Lead2Mask) == Lead2Code) begin
                    n_acc     = {11'd0, b[4:0]};
                    n_pending = 3'd1;
                end else if ((b & Lead3Mask) == Lead3Code) begin
                    n_acc     = {12'd0, b[3:0]};
                    n_pending = 3'd2;
                end else if ((b & Lead4Mask) == Lead4Code) begin
                    n_acc     = {13'd0, b[2:0]};
                    n_pending = 3'd3;
                end else if ((b & Lead5Mask) == Lead5Code) begin
                    n_skip    = 1'b1;
                    n_pending = 3'd4;
                end else if ((b & Lead6Mask) == Lead6Code) begin
                    n_skip    = 1'b1;
                    n_pending = 3'd5;
                end

                if (n_pos == PosSat) begin
                    n_bom = 1'b0;
                end

                if (emit) begin
                    if (mark_done) begin
                        n_bom = 1'b0;
                    end else begin
                        unit_ok = 1'b1;
                        unit    = n_acc;
                        n_count = r_count + 16'd1;
                    end
                end
            end

            if (i_in_item.last) begin
                end_s = 1'b1;
            end
            if (end_s) begin
                n_term    = 1'b1;
                n_pending = 3'd0;
                n_skip    = 1'b0;
            end
        end
    end

    assign o_push                    = unit_ok || end_s;
    assign o_push_item.code_unit     = unit;
    assign o_push_item.unit_valid    = unit_ok;
    assign o_push_item.end_of_string = end_s;
    assign o_push_item.units_written = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 3'd0;
            r_skip    <= 1'b0;
            r_pos     <= 2'd0;
            r_bom     <= 1'b1;
            r_count   <= 16'd0;
            r_term    <= 1'b0;
        end else begin
            r_pending <= n_pending;
            r_skip    <= n_skip;
            r_pos     <= n_pos;
            r_bom     <= n_bom;
            r_count   <= n_count;
            r_term    <= n_term;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

endmodule

[design/u2d_queue.sv]
// Small FIFO between the decode front end and the output stage.
// Depends on u2d_pkg. DEPTH from 2 to 16.
module u2d_queue
    import u2d_pkg::*;
#(
    parameter int unsigned DEPTH = QueueDepthDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_q_item   i_push_item,
    input  logic      i_pop,
    output t_q_item   o_head,
    output t_q_status o_status
);

    localparam int unsigned PtrW = $clog2(DEPTH);
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    t_q_item         r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + PtrW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + PtrW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CntW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CntW'(1);
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CntFull);
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

[design/u2d_back.sv]
// Output stage: pops the queue, flags the unit limit, holds the result register.
// Depends on u2d_pkg; fed by u2d_queue.
module u2d_back
    import u2d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_status   i_q_status,
    input  t_q_item     i_head,
    input  logic [15:0] i_max_units,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item
);

    logic      r_valid, n_valid;
    t_out_item r_item;

    assign o_pop = !i_q_status.empty && (!r_valid || i_out_ready);

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // the user must change max_units only while nothing is in flight; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item.code_unit     <= i_head.code_unit;
            r_item.unit_valid    <= i_head.unit_valid;
            r_item.end_of_string <= i_head.end_of_string;
            r_item.units_written <= i_head.units_written;
            r_item.stopped_full  <= (i_head.units_written >= i_max_units);
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

[design/utf8_to_ucs2_decoder_unit.sv]
// Channel   Signals                            Request moves
// --------  ---------------------------------  -------------------------------
// input     i_in_valid / o_in_ready            i_in_item: one byte + last flag
// output    o_out_valid / i_out_ready          o_out_item: unit or end result
// config    i_cfg_we / i_cfg_data              max_units, no read-back
//
// One byte per cycle while the queue is not full; the front end decodes in the cycle it takes the request.
// A result passes through the queue and then the back-end result register before it is valid at the output.
// o_in_ready drops only when the QUEUE_DEPTH-entry queue is full.
// Synchronous active-low reset; no clearing pass, ready the cycle after reset.
// Top level: config register and the front / queue / back chain. Depends on u2d_pkg.
module utf8_to_ucs2_decoder_unit
    import u2d_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_max_units;
    t_q_status   q_status;
    logic        push;
    t_q_item     push_item;
    logic        pop;
    t_q_item     head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_units <= MaxUnitsReset;
        end else if (i_cfg_we) begin
            r_max_units <= i_cfg_data;
        end
    end

    u2d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_max_units (r_max_units),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_item (push_item)
    );

    u2d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (q_status)
    );

    u2d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_head      (head),
        .i_max_units (r_max_units),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

[design/u2d_checker.sv]
// Port-level checks for utf8_to_ucs2_decoder_unit, attached by bind.
// Depends on u2d_pkg.
module u2d_checker
    import u2d_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input t_in_item    i_in_item,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out_item   o_out_item,
    input logic        i_cfg_we,
    input logic [15:0] i_cfg_data
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    a_empty_unit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.unit_valid |-> o_out_item.code_unit == 16'd0)
        else $error("code unit set without unit_valid");

    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.unit_valid || o_out_item.end_of_string)
        else $error("result with neither unit nor end");

    a_unit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.unit_valid |-> o_out_item.units_written != 16'd0)
        else $error("unit emitted with zero count");

endmodule

bind utf8_to_ucs2_decoder_unit u2d_checker u_u2d_checker (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for utf8_to_ucs2_decoder_unit: a directed table, then random UTF-8.
// Results are checked against a decoder model kept in this file. Depends on u2d_pkg and the RTL.
module tb_top;
    import u2d_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DIR_LEN     = 28;

    typedef enum logic [1:0] {ROW_MODEL, ROW_NONE, ROW_UNIT} t_row_kind;

    typedef struct packed {
        logic [7:0]  in_byte;
        t_row_kind   kind;
        logic [15:0] unit;
        logic [15:0] count;
    } t_plan_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_item;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;

    utf8_to_ucs2_decoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    // decoder model state
    logic [2:0]  pend_cnt;
    logic        skipping;
    logic [15:0] acc;
    logic [1:0]  pos;
    logic        bom_live;
    logic [15:0] units;
    logic        done;
    logic [15:0] limit;

    t_out_item predicted_units[$];
    int        mismatches   = 0;
    int        results_seen = 0;
    int        sent_bytes   = 0;
    int        cfg_writes   = 0;
    int        gap_pct      = 6;
    int        idle_cycles  = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // returns 1 when the byte produces a result
    function automatic bit decode_byte(input t_in_item it, output t_out_item res);
        logic [7:0] b;
        logic [7:0] want;
        bit fin;
        bit emitted;
        bit got_unit;
        bit mark_done;
        b         = it.in_byte;
        fin       = 1'b0;
        emitted   = 1'b0;
        got_unit  = 1'b0;
        mark_done = 1'b0;
        res       = '0;
        if (done) return 1'b0;
        if (b == 8'h00) begin
            fin = 1'b1;
        end else if (units >= limit) begin
            pend_cnt = 3'd0;
            skipping = 1'b0;
        end else begin
            if (bom_live) begin
                want = (pos == 2'd0) ? BomByte0 : (pos == 2'd1) ? BomByte1 : BomByte2;
                if (pos == PosSat || b != want) bom_live = 1'b0;
                else if (pos == PosBomLast) mark_done = 1'b1;
            end
            if (pos != PosSat) pos = pos + 2'd1;

            if (pend_cnt != 3'd0) begin
                pend_cnt = pend_cnt - 3'd1;
                if (!skipping) begin
                    acc = {acc[9:0], b[5:0]};
                    if (pend_cnt == 3'd0) emitted = 1'b1;
                end else if (pend_cnt == 3'd0) begin
                    skipping = 1'b0;
                end
            end else if (!b[7]) begin
                acc     = {8'h00, b};
                emitted = 1'b1;
            end else if ((b & Lead2Mask) == Lead2Code) begin
                acc      = {11'd0, b[4:0]};
                pend_cnt = 3'd1;
            end else if ((b & Lead3Mask) == Lead3Code) begin
                acc      = {12'd0, b[3:0]};
                pend_cnt = 3'd2;
            end else if ((b & Lead4Mask) == Lead4Code) begin
                acc      = {13'd0, b[2:0]};
                pend_cnt = 3'd3;
            end else if ((b & Lead5Mask) == Lead5Code) begin
                skipping = 1'b1;
                pend_cnt = 3'd4;
            end else if ((b & Lead6Mask) == Lead6Code) begin
                skipping = 1'b1;
                pend_cnt = 3'd5;
            end

            if (pos == PosSat) bom_live = 1'b0;

            if (emitted) begin
                // the third mark byte completes a sequence but is swallowed
                if (mark_done) begin
                    bom_live = 1'b0;
                end else begin
                    got_unit = 1'b1;
                    units    = units + 16'd1;
                end
            end
        end

        if (it.last) fin = 1'b1;
        if (fin) begin
            done     = 1'b1;
            pend_cnt = 3'd0;
            skipping = 1'b0;
        end
        if (!got_unit && !fin) return 1'b0;
        res.code_unit     = got_unit ? acc : 16'h0000;
        res.unit_valid    = got_unit;
        res.end_of_string = fin;
        res.units_written = units;
        res.stopped_full  = (units >= limit);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    // called at a falling edge; returns at the falling edge after the request is taken
    task automatic push_byte(input t_in_item it, input t_row_kind kind = ROW_MODEL,
                             input t_out_item typed = '0);
        t_out_item res;
        bit        has;
        while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        has = decode_byte(it, res);
        if (kind == ROW_UNIT) predicted_units.push_back(typed);
        else if (kind == ROW_MODEL && has) predicted_units.push_back(res);
        sent_bytes++;
        @(negedge i_clk);
    endtask

    // the register is written only with the pipeline drained
    task automatic set_limit(input logic [15:0] value);
        i_in_valid <= 1'b0;
        while (predicted_units.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        limit      = value;
        cfg_writes++;
    endtask

    // one lead byte plus its continuation bytes, mostly well formed
    task automatic rand_sequence();
        int         pick;
        int         n;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            b = 8'($urandom_range(8'h01, 8'h7F)); n = 0;
        end else if (pick < 60) begin
            b = 8'($urandom_range(8'hC0, 8'hDF)); n = 1;
        end else if (pick < 75) begin
            b = 8'($urandom_range(8'hE0, 8'hEF)); n = 2;
        end else if (pick < 85) begin
            b = 8'($urandom_range(8'hF0, 8'hF7)); n = 3;
        end else if (pick < 90) begin
            b = 8'($urandom_range(8'hF8, 8'hFB)); n = 4;
        end else if (pick < 93) begin
            b = 8'($urandom_range(8'hFC, 8'hFD)); n = 5;
        end else begin
            b = 8'($urandom_range(8'h01, 8'hFF)); n = 0;
        end
        push_byte(t_in_item'{b, 1'b0});
        for (int k = 0; k < n; k++) begin
            if (pick < 85 && $urandom_range(0, 99) >= 3) b = 8'($urandom_range(8'h80, 8'hBF));
            else b = 8'($urandom_range(8'h01, 8'hFF));
            push_byte(t_in_item'{b, 1'b0});
        end
    endtask

    task automatic run_random(input int upto);
        while (sent_bytes < upto) rand_sequence();
    endtask

    // receiver stalls
    always @(negedge i_clk) begin
        i_out_ready <= (gap_pct == 0) || ($urandom_range(0, 99) >= gap_pct);
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (predicted_units.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_out_item));
            end else begin
                want = predicted_units.pop_front();
                if (o_out_item.code_unit !== want.code_unit)
                    report_mismatch($sformatf("code_unit %h, want %h",
                                              o_out_item.code_unit, want.code_unit));
                if (o_out_item.unit_valid !== want.unit_valid)
                    report_mismatch($sformatf("unit_valid %b, want %b",
                                              o_out_item.unit_valid, want.unit_valid));
                if (o_out_item.end_of_string !== want.end_of_string)
                    report_mismatch($sformatf("end_of_string %b, want %b",
                                              o_out_item.end_of_string, want.end_of_string));
                if (o_out_item.units_written !== want.units_written)
                    report_mismatch($sformatf("units_written %0d, want %0d",
                                              o_out_item.units_written, want.units_written));
                if (o_out_item.stopped_full !== want.stopped_full)
                    report_mismatch($sformatf("stopped_full %b, want %b",
                                              o_out_item.stopped_full, want.stopped_full));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("utf8_to_ucs2_decoder_unit verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_plan_row plan [DIR_LEN];
        int        ending;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        pend_cnt    = 3'd0;
        skipping    = 1'b0;
        acc         = 16'h0000;
        pos         = 2'd0;
        bom_live    = 1'b1;
        units       = 16'd0;
        done        = 1'b0;
        limit       = MaxUnitsReset;

        plan = '{
            // byte-order mark at the head is dropped
            '{8'hEF, ROW_NONE, 16'h0000, 16'd0},
            '{8'hBB, ROW_NONE, 16'h0000, 16'd0},
            '{8'hBF, ROW_NONE, 16'h0000, 16'd0},
            '{8'h41, ROW_UNIT, 16'h0041, 16'd1},
            // stray bytes
            '{8'h80, ROW_NONE, 16'h0000, 16'd0},
            '{8'hFE, ROW_NONE, 16'h0000, 16'd0},
            '{8'hFF, ROW_NONE, 16'h0000, 16'd0},
            '{8'hC2, ROW_MODEL, 16'h0000, 16'd0},
            '{8'hA9, ROW_MODEL, 16'h0000, 16'd0},
            '{8'hE2, ROW_MODEL, 16'h0000, 16'd0},
            '{8'h82, ROW_MODEL, 16'h0000, 16'd0},
            '{8'hAC, ROW_MODEL, 16'h0000, 16'd0},
            // four-byte form, truncated to 16 bits
            '{8'hF0, ROW_MODEL, 16'h0000, 16'd0},
            '{8'h9F, ROW_MODEL, 16'h0000, 16'd0},
            '{8'h98, ROW_MODEL, 16'h0000, 16'd0},
            '{8'h80, ROW_MODEL, 16'h0000, 16'd0},
            // five- and six-byte leads swallow what follows
            '{8'hF8, ROW_NONE, 16'h0000, 16'd0},
            '{8'h01, ROW_NONE, 16'h0000, 16'd0},
            '{8'h7F, ROW_NONE, 16'h0000, 16'd0},
            '{8'hFF, ROW_NONE, 16'h0000, 16'd0},
            '{8'h80, ROW_NONE, 16'h0000, 16'd0},
            '{8'hFC, ROW_NONE, 16'h0000, 16'd0},
            '{8'hC0, ROW_NONE, 16'h0000, 16'd0},
            '{8'h3F, ROW_NONE, 16'h0000, 16'd0},
            '{8'hAA, ROW_NONE, 16'h0000, 16'd0},
            '{8'h55, ROW_NONE, 16'h0000, 16'd0},
            '{8'hFE, ROW_NONE, 16'h0000, 16'd0},
            '{8'h7F, ROW_UNIT, 16'h007F, 16'd5}
        };

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < DIR_LEN; r++)
            push_byte(t_in_item'{plan[r].in_byte, 1'b0}, plan[r].kind,
                      t_out_item'{plan[r].unit, 1'b1, 1'b0, plan[r].count, 1'b0});

        run_random(280);
        set_limit(units + 16'($urandom_range(1, 6)));
        run_random(340);
        set_limit(16'hFFFF);
        gap_pct = 0;
        run_random(540);
        gap_pct = 6;

        // limit lowered with a sequence open: the partial unit is dropped
        push_byte(t_in_item'{8'hE2, 1'b0});
        set_limit(units);
        push_byte(t_in_item'{8'h82, 1'b0});
        push_byte(t_in_item'{8'hAC, 1'b0});
        set_limit(units + 16'd40);
        push_byte(t_in_item'{8'h82, 1'b0});
        push_byte(t_in_item'{8'h5A, 1'b0});

        set_limit(16'd1);
        run_random(560);
        set_limit(16'hFFFF);
        run_random(800);

        ending = $urandom_range(0, 2);
        case (ending)
            0: begin
                push_byte(t_in_item'{8'hE2, 1'b0});
                push_byte(t_in_item'{8'h00, 1'b1});
            end
            1: push_byte(t_in_item'{8'h5A, 1'b1});
            default: push_byte(t_in_item'{8'hF0, 1'b1});
        endcase
        // string closed: nothing more comes out
        push_byte(t_in_item'{8'h00, 1'b1});
        push_byte(t_in_item'{8'h41, 1'b0});
        push_byte(t_in_item'{8'hC2, 1'b1});
        push_byte(t_in_item'{8'hFF, 1'b0});
        i_in_valid <= 1'b0;

        while (predicted_units.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("Run: %0d bytes sent, %0d results checked, %0d limit writes, ending form %0d",
                 sent_bytes, results_seen, cfg_writes, ending);
        $display("Final unit count %0d, mismatches %0d", units, mismatches);
        if (mismatches == 0) begin
            $display("utf8_to_ucs2_decoder_unit verification clean");
        end else begin
            $display("utf8_to_ucs2_decoder_unit verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
design/u2d_pkg.sv
design/u2d_front.sv
design/u2d_queue.sv
design/u2d_back.sv
design/utf8_to_ucs2_decoder_unit.sv
design/u2d_checker.sv
tb/sv/tb_top.sv
